@@ hw/rtl/frc_pkg.sv @@
// Shared types, constants and CRC helper for the frame receiver with ACK generator.
// No dependencies; every other RTL file imports this package.
package frc_pkg;

   // Largest accepted frame in bytes (start word through CRC).
   localparam int MAX_FRAME_BYTES = 256;
   // Frame byte counter and stored payload length width.
   localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
   // Largest payload length that still fits in the frame buffer.
   localparam logic [15:0] MAX_PAYLOAD = 16'(MAX_FRAME_BYTES - 10);

   // Request kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   // Framing constants
   localparam logic [7:0] SOF_LO         = 8'hAA;
   localparam logic [7:0] SOF_HI         = 8'h55;
   localparam logic [7:0] PROTO_VERSION  = 8'h01;
   localparam logic [7:0] TYPE_ACK       = 8'h80;
   localparam logic [7:0] TYPE_HEARTBEAT = 8'h02;
   localparam logic [7:0] ACK_PAYLOAD    = 8'd12;
   localparam int         HEARTBEAT_MIN  = 8;

   // ACK frame layout
   localparam int ACK_LEN    = 22;
   localparam int ACK_IDX_W  = $clog2(ACK_LEN);
   localparam int ACK_CRC_LO = 20;
   localparam int ACK_CRC_HI = 21;

   // ACK status codes
   localparam logic STATUS_HEARTBEAT = 1'b0;
   localparam logic STATUS_OTHER     = 1'b1;

   // CRC-16-CCITT
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Pending ACK queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Everything the ACK transmitter needs for one acknowledge frame
   typedef struct packed {
      logic [15:0] tx_seq;
      logic [15:0] frame_seq;
      logic [7:0]  frame_type;
      logic        status;
      logic [31:0] good_count;
      logic [31:0] heartbeat_count;
   } ack_desc_type;

   // One byte through CRC-16-CCITT, MSB first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // CRC state after the start word
   localparam logic [15:0] CRC_AFTER_SOF = crc16_update(crc16_update(CRC_INIT, SOF_LO), SOF_HI);

endpackage

@@ hw/rtl/frame_receiver_crc_ack.sv @@
// Frame receiver with CRC-16 check and ACK generator (top level).
// Depends on frc_pkg, frc_front, frc_ack_queue and frc_ack_tx.
//
// Usage:
//   Request channel (req_*): one link byte or a connection reset per request,
//   taken when req_valid is high and req_stall is low. The parser takes one
//   request per cycle while req_stall is low; a connection reset drops any partial frame.
//   Response channel (rsp_*): a 22-byte ACK frame for each frame whose CRC
//   checks, one byte per transfer, rsp_last_of_frame set on its final byte.
//   ACK start: with the transmitter idle, a good frame's descriptor is written
//   into the queue as its last CRC byte is taken, then the first ACK byte is
//   registered out; the rest follow one per cycle while rsp_stall is low.
//   Throughput: one request per cycle while req_stall is low. Each ACK holds the
//   byte-serial transmitter until its last byte is loaded; a two-entry
//   descriptor queue sits between the parser and the transmitter, and req_stall
//   is high only while both entries are pending.
//   When the receiver stalls the response channel, the ACK byte holds and the
//   transmitter waits; parsing continues until the queue fills.
//   Reset (synchronous, active high): hunting restarts, counters clear, the
//   transmit sequence returns to 1 and the queue empties. No clearing pass.
module frame_receiver_crc_ack
   import frc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_ack_byte,
   output logic       rsp_last_of_frame
);

   logic         accept;
   logic         push;
   ack_desc_type push_desc;
   logic         full;
   logic         pop;
   logic         head_valid;
   ack_desc_type head_desc;

   // Stall requests only while no queue slot is free
   assign req_stall = full;
   assign accept    = req_valid && !full;

   frc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .rx_byte   (req_rx_byte),
      .push      (push),
      .push_desc (push_desc)
   );

   frc_ack_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   frc_ack_tx u_tx (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_desc         (head_desc),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ack_byte      (rsp_ack_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

@@ hw/rtl/frc_front.sv @@
// Front end: start-word hunt, header and payload parse, CRC check, frame counters.
// Depends on frc_pkg; pushes one ACK descriptor per good frame.
module frc_front
   import frc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         kind,
   input  logic [7:0]   rx_byte,
   output logic         push,
   output ack_desc_type push_desc
);

   localparam logic [1:0] PH_HUNT_LO = 2'd0;
   localparam logic [1:0] PH_HUNT_HI = 2'd1;
   localparam logic [1:0] PH_FRAME   = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      good_ff, good_in;
   logic [31:0]      hb_ff, hb_in;
   logic [15:0]      txseq_ff, txseq_in;

   logic [CNT_W:0]   body_end;
   logic [CNT_W:0]   idx_ext;
   logic [15:0]      len_full;
   logic             is_hb;

   assign idx_ext  = {1'b0, cnt_ff};
   assign body_end = {1'b0, len_ff} + (CNT_W+1)'(8);
   assign len_full = {rx_byte, len_lo_ff};
   assign is_hb    = (type_ff == TYPE_HEARTBEAT) && (len_ff >= CNT_W'(HEARTBEAT_MIN));

   // Parse one request
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      len_lo_in = len_lo_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      good_in   = good_ff;
      hb_in     = hb_ff;
      txseq_in  = txseq_ff;
      push      = 1'b0;

      push_desc.tx_seq          = txseq_ff;
      push_desc.frame_seq       = seq_ff;
      push_desc.frame_type      = type_ff;
      push_desc.status          = is_hb ? STATUS_HEARTBEAT : STATUS_OTHER;
      push_desc.good_count      = good_ff + 32'd1;
      push_desc.heartbeat_count = is_hb ? (hb_ff + 32'd1) : hb_ff;

      if (accept) begin
         if (kind == KIND_RESET) begin
            phase_in = PH_HUNT_LO;
            cnt_in   = '0;
         end else begin
            case (phase_ff)
               PH_HUNT_HI: begin
                  if (rx_byte == SOF_HI) begin
                     phase_in = PH_FRAME;
                     cnt_in   = CNT_W'(2);
                     crc_in   = CRC_AFTER_SOF;
                  end else if (rx_byte != SOF_LO) begin
                     phase_in = PH_HUNT_LO;
                  end
               end
               PH_FRAME: begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (idx_ext < body_end) begin
                     // header or payload byte
                     crc_in = crc16_update(crc_ff, rx_byte);
                     case (cnt_ff)
                        CNT_W'(3): type_in = rx_byte;
                        CNT_W'(4): seq_in = {seq_ff[15:8], rx_byte};
                        CNT_W'(5): seq_in = {rx_byte, seq_ff[7:0]};
                        CNT_W'(6): len_lo_in = rx_byte;
                        CNT_W'(7): begin
                           if (len_full > MAX_PAYLOAD) begin
                              phase_in = PH_HUNT_LO;
                              cnt_in   = '0;
                              len_in   = '0;
                           end else begin
                              len_in = CNT_W'(len_full);
                           end
                        end
                        default: ;
                     endcase
                  end else if (idx_ext == body_end) begin
                     crc_lo_in = rx_byte;
                  end else begin
                     // final CRC byte: check and count
                     phase_in = PH_HUNT_LO;
                     cnt_in   = '0;
                     if ({rx_byte, crc_lo_ff} == crc_ff) begin
                        push     = 1'b1;
                        good_in  = push_desc.good_count;
                        hb_in    = push_desc.heartbeat_count;
                        txseq_in = txseq_ff + 16'd1;
                     end
                  end
               end
               default: begin
                  phase_in = (rx_byte == SOF_LO) ? PH_HUNT_HI : PH_HUNT_LO;
               end
            endcase
         end
      end
   end

   // Control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_LO;
         cnt_ff   <= '0;
         len_ff   <= '0;
         crc_ff   <= CRC_INIT;
         good_ff  <= '0;
         hb_ff    <= '0;
         txseq_ff <= 16'd1;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         good_ff  <= good_in;
         hb_ff    <= hb_in;
         txseq_ff <= txseq_in;
      end
   end

   // Header payload registers
   always_ff @(posedge clock) begin
      len_lo_ff <= len_lo_in;
      crc_lo_ff <= crc_lo_in;
      type_ff   <= type_in;
      seq_ff    <= seq_in;
   end

   // Inside a frame the counter is past the start word
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FRAME |-> cnt_ff >= CNT_W'(2))
      else $error("frame byte counter below start word while in frame");

   // A good frame always returns the parser to hunting
   assert property (@(posedge clock) disable iff (reset)
      push |=> phase_ff == PH_HUNT_LO && cnt_ff == '0)
      else $error("parser not back to hunting after good frame");

endmodule

@@ hw/rtl/frc_ack_queue.sv @@
// Short queue of pending ACK descriptors between parser and transmitter.
// Depends on frc_pkg for the descriptor type and depth.
module frc_ack_queue
   import frc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ack_desc_type push_desc,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output ack_desc_type head_desc
);

   ack_desc_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = mem_ff[rd_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_desc;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("ACK queue occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full ACK queue");

endmodule

@@ hw/rtl/frc_ack_tx.sv @@
// Back end: serializes one ACK descriptor into a 22-byte frame with trailing CRC.
// Depends on frc_pkg; drives the registered response channel.
module frc_ack_tx
   import frc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  ack_desc_type head_desc,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_ack_byte,
   output logic         rsp_last_of_frame
);

   logic [ACK_IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 load;
   logic [7:0]           cur_byte;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && (idx_ff == ACK_IDX_W'(ACK_CRC_HI));

   // Select the frame byte at the current position
   always_comb begin
      case (idx_ff)
         ACK_IDX_W'(0):  cur_byte = SOF_LO;
         ACK_IDX_W'(1):  cur_byte = SOF_HI;
         ACK_IDX_W'(2):  cur_byte = PROTO_VERSION;
         ACK_IDX_W'(3):  cur_byte = TYPE_ACK;
         ACK_IDX_W'(4):  cur_byte = head_desc.tx_seq[7:0];
         ACK_IDX_W'(5):  cur_byte = head_desc.tx_seq[15:8];
         ACK_IDX_W'(6):  cur_byte = ACK_PAYLOAD;
         ACK_IDX_W'(7):  cur_byte = 8'h00;
         ACK_IDX_W'(8):  cur_byte = head_desc.frame_seq[7:0];
         ACK_IDX_W'(9):  cur_byte = head_desc.frame_seq[15:8];
         ACK_IDX_W'(10): cur_byte = head_desc.frame_type;
         ACK_IDX_W'(11): cur_byte = {7'd0, head_desc.status};
         ACK_IDX_W'(12): cur_byte = head_desc.good_count[7:0];
         ACK_IDX_W'(13): cur_byte = head_desc.good_count[15:8];
         ACK_IDX_W'(14): cur_byte = head_desc.good_count[23:16];
         ACK_IDX_W'(15): cur_byte = head_desc.good_count[31:24];
         ACK_IDX_W'(16): cur_byte = head_desc.heartbeat_count[7:0];
         ACK_IDX_W'(17): cur_byte = head_desc.heartbeat_count[15:8];
         ACK_IDX_W'(18): cur_byte = head_desc.heartbeat_count[23:16];
         ACK_IDX_W'(19): cur_byte = head_desc.heartbeat_count[31:24];
         ACK_IDX_W'(ACK_CRC_LO): cur_byte = crc_ff[7:0];
         ACK_IDX_W'(ACK_CRC_HI): cur_byte = crc_ff[15:8];
         default:        cur_byte = 8'h00;
      endcase
   end

   // Advance through the frame when the output register is free
   always_comb begin
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = (idx_ff == ACK_IDX_W'(ACK_CRC_HI));
         if (idx_ff < ACK_IDX_W'(ACK_CRC_LO)) begin
            crc_in = crc16_update(crc_ff, cur_byte);
         end
         if (idx_ff == ACK_IDX_W'(ACK_CRC_HI)) begin
            idx_in = '0;
            crc_in = CRC_INIT;
         end else begin
            idx_in = idx_ff + ACK_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_ack_byte      = byte_ff;
   assign rsp_last_of_frame = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("ACK descriptor popped from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0 && crc_ff == CRC_INIT)
      else $error("transmitter not rewound after last ACK byte");

endmodule

@@ sim/frame_receiver_crc_ack_tb.sv @@
`timescale 1ns / 100ps
// Testbench for frame_receiver_crc_ack: drives link bytes and connection resets,
// predicts every ACK frame and checks the ACK bytes in send order.
// Depends on frc_pkg and the frame_receiver_crc_ack RTL.
module frame_receiver_crc_ack_tb;
   import frc_pkg::*;

   localparam int STUCK_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_ITEMS_PER_PHASE = 80;

   // Frame byte offsets
   localparam int OFS_TYPE   = 3;
   localparam int OFS_SEQ_LO = 4;
   localparam int OFS_SEQ_HI = 5;
   localparam int OFS_LEN_LO = 6;
   localparam int OFS_LEN_HI = 7;
   localparam int HDR_BYTES  = 8;
   localparam int FRAME_OVERHEAD = 10;

   typedef enum logic [1:0] {SEEK_LO, SEEK_HI, IN_FRAME} hunt_state_type;
   typedef enum logic [1:0] {SRC_RAW, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD} byte_src_type;

   typedef struct {
      logic          kind;
      byte_src_type  src;
      logic [7:0]    data;
      bit            acks;
   } link_request_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } ack_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = KIND_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_ack_byte;
   logic       rsp_last_of_frame;

   // Receiver state as predicted
   hunt_state_type   hunt = SEEK_LO;
   logic [CNT_W-1:0] rx_index = '0;
   logic [CNT_W-1:0] rx_len = '0;
   logic [15:0]      rx_crc = CRC_INIT;
   logic [7:0]       rx_crc_lo = 8'h00;
   logic [7:0]       rx_type = 8'h00;
   logic [15:0]      rx_seq = 16'h0000;
   logic [31:0]      good_frames = 32'd0;
   logic [31:0]      heartbeats = 32'd0;
   logic [15:0]      ack_seq = 16'd1;

   ack_byte_type pending_ack_bytes[$];
   int mismatch_count = 0;
   int req_idle_pct = 9;
   int rsp_idle_pct = 78;
   int stuck_cycles = 0;
   int phase_items = 0;

   // Directed requests: extremes, sliding start word, good, bad CRC and
   // oversized frames (length 0x0100 would wrap an 8-bit length)
   link_request_type directed_rows [31] = '{
      '{KIND_RESET, SRC_RAW,     8'hFF, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hAA, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hAA, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h55, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hFF, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h02, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h34, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h12, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_CRC_LO,  8'h00, 1'b0},
      '{KIND_BYTE,  SRC_CRC_HI,  8'h00, 1'b1},
      '{KIND_BYTE,  SRC_RAW,     8'hAA, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h55, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h80, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hFF, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hFF, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_CRC_LO,  8'h00, 1'b0},
      '{KIND_BYTE,  SRC_CRC_BAD, 8'h01, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'hAA, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h55, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h01, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h01, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h00, 1'b0},
      '{KIND_BYTE,  SRC_RAW,     8'h01, 1'b0}
   };

   frame_receiver_crc_ack dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ack_byte      (rsp_ack_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always #1 clock = ~clock;

   // CRC-16-CCITT, one data bit at a time, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ data[i];
         r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   // Assemble the 22-byte ACK frame and queue its bytes
   function automatic void queue_ack_frame(input logic status);
      logic [7:0]  f [ACK_LEN];
      logic [15:0] crc;
      f[0] = SOF_LO;
      f[1] = SOF_HI;
      f[2] = PROTO_VERSION;
      f[3] = TYPE_ACK;
      f[4] = ack_seq[7:0];
      f[5] = ack_seq[15:8];
      f[6] = ACK_PAYLOAD;
      f[7] = 8'h00;
      f[8] = rx_seq[7:0];
      f[9] = rx_seq[15:8];
      f[10] = rx_type;
      f[11] = {7'b0, status};
      for (int i = 0; i < 4; i++) begin
         f[12 + i] = good_frames[8*i +: 8];
         f[16 + i] = heartbeats[8*i +: 8];
      end
      crc = CRC_INIT;
      for (int i = 0; i < ACK_CRC_LO; i++) crc = crc16_step(crc, f[i]);
      f[ACK_CRC_LO] = crc[7:0];
      f[ACK_CRC_HI] = crc[15:8];
      for (int i = 0; i < ACK_LEN; i++)
         pending_ack_bytes.push_back(ack_byte_type'{f[i], i == ACK_LEN - 1});
      ack_seq = ack_seq + 16'd1;
   endfunction

   // Advance the receiver by one request; return 1 when it yields an ACK
   function automatic bit predict_link_request(input logic kind, input logic [7:0] b);
      logic [CNT_W-1:0] pos;
      logic [15:0]      full_len;
      if (kind == KIND_RESET) begin
         hunt = SEEK_LO;
         rx_index = '0;
         return 1'b0;
      end
      case (hunt)
         SEEK_HI: begin
            if (b == SOF_HI) begin
               hunt = IN_FRAME;
               rx_index = CNT_W'(2);
               rx_crc = crc16_step(crc16_step(CRC_INIT, SOF_LO), SOF_HI);
            end else if (b != SOF_LO) begin
               hunt = SEEK_LO;
            end
            return 1'b0;
         end
         IN_FRAME: ;
         default: begin
            hunt = (b == SOF_LO) ? SEEK_HI : SEEK_LO;
            return 1'b0;
         end
      endcase

      pos = rx_index;
      rx_index = pos + 1'b1;
      // header and payload feed the CRC
      if (int'(pos) < HDR_BYTES || int'(pos) < HDR_BYTES + int'(rx_len)) begin
         rx_crc = crc16_step(rx_crc, b);
         case (int'(pos))
            OFS_TYPE:   rx_type = b;
            OFS_SEQ_LO: rx_seq = {8'h00, b};
            OFS_SEQ_HI: rx_seq[15:8] = b;
            OFS_LEN_LO: rx_len = CNT_W'(b);
            OFS_LEN_HI: begin
               // full 16-bit length, no wrap
               full_len = {b, 8'(rx_len)};
               if (FRAME_OVERHEAD + int'(full_len) > MAX_FRAME_BYTES) begin
                  hunt = SEEK_LO;
                  rx_index = '0;
                  rx_len = '0;
               end else begin
                  rx_len = CNT_W'(full_len);
               end
            end
            default: ;
         endcase
         return 1'b0;
      end
      if (int'(pos) == HDR_BYTES + int'(rx_len)) begin
         rx_crc_lo = b;
         return 1'b0;
      end

      // final CRC byte closes the frame
      hunt = SEEK_LO;
      rx_index = '0;
      if ({b, rx_crc_lo} != rx_crc) return 1'b0;
      good_frames = good_frames + 32'd1;
      if (rx_type == TYPE_HEARTBEAT && int'(rx_len) >= HEARTBEAT_MIN) begin
         heartbeats = heartbeats + 32'd1;
         queue_ack_frame(STATUS_HEARTBEAT);
      end else begin
         queue_ack_frame(STATUS_OTHER);
      end
      return 1'b1;
   endfunction

   function automatic link_request_type link_byte(input logic [7:0] d);
      return link_request_type'{KIND_BYTE, SRC_RAW, d, 1'b0};
   endfunction

   // Drive one request, wait for it to be taken, then predict
   task automatic send_request(input link_request_type r, output bit acked);
      logic [7:0] b;
      case (r.src)
         SRC_CRC_LO:  b = rx_crc[7:0];
         SRC_CRC_HI:  b = rx_crc[15:8];
         SRC_CRC_BAD: b = rx_crc[15:8] ^ r.data;
         default:     b = r.data;
      endcase
      // hold off the request now and then
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      acked = predict_link_request(r.kind, b);
      phase_items++;
   endtask

   // One random frame: mostly well formed, some noise, oversized,
   // bad CRC or cut short by a connection reset
   task automatic send_random_frame(input int forced_len);
      link_request_type frame_q[$];
      link_request_type r;
      int               shape;
      int               len;
      int               cut;
      logic [7:0]       ftype;
      bit               acked;
      shape = (forced_len >= 0) ? 99 : $urandom_range(0, 99);
      if (shape < 12) begin
         // line noise with start bytes and resets mixed in
         repeat ($urandom_range(1, 4)) begin
            r = link_byte(8'($urandom));
            if ($urandom_range(0, 3) == 0) r.data = SOF_LO;
            if ($urandom_range(0, 9) == 0) r.kind = KIND_RESET;
            frame_q.push_back(r);
         end
      end else begin
         ftype = ($urandom_range(0, 99) < 35) ? TYPE_HEARTBEAT : 8'($urandom);
         if (forced_len >= 0) begin
            len = forced_len;
            ftype = TYPE_HEARTBEAT;
         end else if (shape < 22) begin
            case ($urandom_range(0, 3))
               0, 1:    len = int'(MAX_PAYLOAD) + 1;
               2:       len = $urandom_range(int'(MAX_PAYLOAD) + 1, 255);
               default: len = $urandom_range(256, 65535);
            endcase
         end else if ($urandom_range(0, 19) == 0) begin
            len = $urandom_range(13, 40);
         end else begin
            len = $urandom_range(0, 12);
         end
         if ($urandom_range(0, 4) == 0) frame_q.push_back(link_byte(SOF_LO));
         frame_q.push_back(link_byte(SOF_LO));
         frame_q.push_back(link_byte(SOF_HI));
         frame_q.push_back(link_byte(8'($urandom)));
         frame_q.push_back(link_byte(ftype));
         frame_q.push_back(link_byte(8'($urandom)));
         frame_q.push_back(link_byte(8'($urandom)));
         frame_q.push_back(link_byte(len[7:0]));
         frame_q.push_back(link_byte(len[15:8]));
         if (shape >= 22) begin
            repeat (len) frame_q.push_back(link_byte(8'($urandom)));
            if (shape < 32 && $urandom_range(0, 1) == 0) begin
               frame_q.push_back(link_byte(8'($urandom)));
               frame_q.push_back(link_request_type'{KIND_BYTE, SRC_CRC_HI, 8'h00, 1'b0});
            end else begin
               frame_q.push_back(link_request_type'{KIND_BYTE, SRC_CRC_LO, 8'h00, 1'b0});
               if (shape < 32)
                  frame_q.push_back(link_request_type'{KIND_BYTE, SRC_CRC_BAD,
                                                       8'($urandom_range(1, 255)), 1'b0});
               else
                  frame_q.push_back(link_request_type'{KIND_BYTE, SRC_CRC_HI, 8'h00, 1'b0});
            end
         end
         // drop the tail and reset the connection partway through
         if (shape >= 32 && shape < 42) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
            frame_q.push_back(link_request_type'{KIND_RESET, SRC_RAW, 8'($urandom), 1'b0});
         end
      end
      foreach (frame_q[i]) send_request(frame_q[i], acked);
   endtask

   // Stall the ACK channel at the current rate
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);

   // Check each ACK byte against the oldest prediction
   always @(posedge clock) begin : ack_check
      ack_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ack_bytes.size() == 0) begin
            $error("ack_byte: expected none, got %h", rsp_ack_byte);
            mismatch_count++;
         end else begin
            want = pending_ack_bytes.pop_front();
            if (rsp_ack_byte !== want.value) begin
               $error("ack_byte: expected %h, got %h", want.value, rsp_ack_byte);
               mismatch_count++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame: expected %b, got %b", want.last, rsp_last_of_frame);
               mismatch_count++;
            end
         end
      end
   end

   // Count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      bit acked;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i], acked);
         if (acked != directed_rows[i].acks) begin
            $error("ack frame: expected %0d, got %0d", directed_rows[i].acks, acked);
            mismatch_count++;
         end
      end

      // random frames: slow receiver, then slow sender, then full rate
      for (int p = 0; p < 3; p++) begin
         req_idle_pct = (p == 0) ? 9 : (p == 1) ? 78 : 0;
         rsp_idle_pct = (p == 0) ? 78 : (p == 1) ? 9 : 0;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS_PER_PHASE) send_random_frame(-1);
      end
      req_valid <= 1'b0;

      // drain outstanding ACK bytes, then watch for strays
      while (pending_ack_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
